[rtl/fvcw_pkg.sv]
// ----------------------------------------------------------------------------
// fvcw_pkg
// Shared types, constants and tables of the flow vector color wheel.
// ----------------------------------------------------------------------------
package fvcw_pkg;

  // Width of the scaled flow components inside the CORDIC datapath.
  localparam int unsigned CW = 36;
  localparam int unsigned ATAN_TABLE_SIZE = 24;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam logic [23:0] FULL_Q16 = 24'd16711680;
  localparam logic [5:0] WHEEL_LAST = 6'd53;

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic               flow_valid;
  } flow_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

  // Payload of one CORDIC stage. The bypass flag marks vectors on an axis,
  // whose angle and radius are already exact.
  typedef struct packed {
    logic                 blank;
    logic                 bypass;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          z;
  } cordic_t;

  // Arctangent of 2^-i as a binary angle, 2^32 is one turn.
  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10680862;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  // Hue wheel entry as {red, green, blue}.
  function automatic logic [23:0] wheel_entry(input logic [5:0] k);
    logic [23:0] c;
    case (k)
      6'd0:  c = 24'hFF0000;
      6'd1:  c = 24'hFF1100;
      6'd2:  c = 24'hFF2200;
      6'd3:  c = 24'hFF3300;
      6'd4:  c = 24'hFF4400;
      6'd5:  c = 24'hFF5500;
      6'd6:  c = 24'hFF6600;
      6'd7:  c = 24'hFF7700;
      6'd8:  c = 24'hFF8800;
      6'd9:  c = 24'hFF9900;
      6'd10: c = 24'hFFAA00;
      6'd11: c = 24'hFFBB00;
      6'd12: c = 24'hFFCC00;
      6'd13: c = 24'hFFDD00;
      6'd14: c = 24'hFFEE00;
      6'd15: c = 24'hFFFF00;
      6'd16: c = 24'hD5FF00;
      6'd17: c = 24'hAAFF00;
      6'd18: c = 24'h80FF00;
      6'd19: c = 24'h55FF00;
      6'd20: c = 24'h2BFF00;
      6'd21: c = 24'h00FF00;
      6'd22: c = 24'h00FF3F;
      6'd23: c = 24'h00FF7F;
      6'd24: c = 24'h00FFBF;
      6'd25: c = 24'h00FFFF;
      6'd26: c = 24'h00E8FF;
      6'd27: c = 24'h00D1FF;
      6'd28: c = 24'h00BAFF;
      6'd29: c = 24'h00A3FF;
      6'd30: c = 24'h008CFF;
      6'd31: c = 24'h0074FF;
      6'd32: c = 24'h005DFF;
      6'd33: c = 24'h0046FF;
      6'd34: c = 24'h002FFF;
      6'd35: c = 24'h0018FF;
      6'd36: c = 24'h0000FF;
      6'd37: c = 24'h1300FF;
      6'd38: c = 24'h2700FF;
      6'd39: c = 24'h3A00FF;
      6'd40: c = 24'h4E00FF;
      6'd41: c = 24'h6200FF;
      6'd42: c = 24'h7500FF;
      6'd43: c = 24'h8900FF;
      6'd44: c = 24'h9C00FF;
      6'd45: c = 24'hB000FF;
      6'd46: c = 24'hC400FF;
      6'd47: c = 24'hD700FF;
      6'd48: c = 24'hEB00FF;
      6'd49: c = 24'hFF00FF;
      6'd50: c = 24'hFF00D5;
      6'd51: c = 24'hFF00AA;
      6'd52: c = 24'hFF0080;
      6'd53: c = 24'hFF0055;
      default: c = 24'hFF002B;
    endcase
    return c;
  endfunction

endpackage

[rtl/flow_vector_color_wheel.sv]
// ----------------------------------------------------------------------------
// flow_vector_color_wheel
// Optical flow vector to RGB color coding on a 55-entry hue wheel.
// ----------------------------------------------------------------------------
// The block takes one flow vector per clock while in_stall_o is low and
// returns one RGB item per vector, in order. The pipeline is the unrolled
// CORDIC, one iteration per register stage, plus two scaling stages and
// three coloring stages. The whole pipeline advances together: it moves
// whenever the output register is empty or being taken, so the input is
// stalled only while a finished item waits at the output. Write
// inv_motion_range (unsigned Q1.16, reset value 65536 for a motion range
// of one) only while no items are in flight.
// Invalid vectors come out black; a zero vector comes out white.
module flow_vector_color_wheel #(
  parameter int unsigned CORDIC_STAGES  = 16,
  parameter int unsigned FLOW_FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fvcw_pkg::flow_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fvcw_pkg::rgb_out_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [16:0]        cfg_data_i
);

  // The atan table ends at 24 entries; more stages add nothing.
  localparam int unsigned NSTG = (CORDIC_STAGES < fvcw_pkg::ATAN_TABLE_SIZE)
                               ? CORDIC_STAGES : fvcw_pkg::ATAN_TABLE_SIZE;

  logic [16:0] inv_range_q;
  logic        en;

  // Every stage advances when the output register can take a new item.
  assign en          = ~out_valid_o | ~out_stall_i;
  assign in_stall_o  = ~en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_range_q <= 17'd65536;
    end else if (cfg_valid_i) begin
      inv_range_q <= cfg_data_i;
    end
  end

  logic              stg_valid [NSTG+1];
  fvcw_pkg::cordic_t stg_data  [NSTG+1];

  fvcw_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .data_i      (in_data_i),
    .inv_range_i (inv_range_q),
    .valid_o     (stg_valid[0]),
    .data_o      (stg_data[0])
  );

  for (genvar i = 0; i < NSTG; i++) begin : g_cordic
    fvcw_cordic_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stg_valid[i]),
      .data_i  (stg_data[i]),
      .valid_o (stg_valid[i+1]),
      .data_o  (stg_data[i+1])
    );
  end

  fvcw_color #(
    .FLOW_FRAC_BITS (FLOW_FRAC_BITS)
  ) u_color (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (stg_valid[NSTG]),
    .data_i  (stg_data[NSTG]),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

[rtl/fvcw_scale.sv]
// ----------------------------------------------------------------------------
// fvcw_scale
// Scales the flow vector by the reciprocal range and folds it into the
// right half plane ahead of the CORDIC stages. Two register stages.
// ----------------------------------------------------------------------------
module fvcw_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fvcw_pkg::flow_in_t data_i,
  input  logic [16:0]        inv_range_i,
  output logic               valid_o,
  output fvcw_pkg::cordic_t  data_o
);

  logic               v1_q;
  logic signed [33:0] px_q, px_d;
  logic signed [33:0] py_q, py_d;
  logic               blank1_q;
  logic               v2_q;
  fvcw_pkg::cordic_t  c_q, c_d;
  logic signed [fvcw_pkg::CW-1:0] nx, ny;

  assign px_d = $signed(data_i.flow_x) * $signed({1'b0, inv_range_i});
  assign py_d = $signed(data_i.flow_y) * $signed({1'b0, inv_range_i});

  always_comb begin
    nx = -$signed({{(fvcw_pkg::CW-34){px_q[33]}}, px_q});
    ny = -$signed({{(fvcw_pkg::CW-34){py_q[33]}}, py_q});
    c_d.blank  = blank1_q;
    c_d.bypass = 1'b0;
    c_d.x      = nx;
    c_d.y      = ny;
    c_d.z      = 32'h0000_0000;
    if (py_q == '0) begin
      // Horizontal vector: angle and radius are exact.
      c_d.bypass = 1'b1;
      c_d.z      = nx[fvcw_pkg::CW-1] ? 32'h8000_0000 : 32'h0000_0000;
      c_d.x      = nx[fvcw_pkg::CW-1] ? -nx : nx;
      c_d.y      = '0;
    end else if (px_q == '0) begin
      c_d.bypass = 1'b1;
      c_d.z      = ny[fvcw_pkg::CW-1] ? 32'hC000_0000 : 32'h4000_0000;
      c_d.x      = ny[fvcw_pkg::CW-1] ? -ny : ny;
      c_d.y      = '0;
    end else if (nx[fvcw_pkg::CW-1]) begin
      // Rotate by a half turn into the right half plane.
      c_d.x = -nx;
      c_d.y = -ny;
      c_d.z = 32'h8000_0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q     <= px_d;
      py_q     <= py_d;
      blank1_q <= ~data_i.flow_valid;
      c_q      <= c_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = c_q;

endmodule

[rtl/fvcw_cordic_stage.sv]
// ----------------------------------------------------------------------------
// fvcw_cordic_stage
// One registered vectoring CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
module fvcw_cordic_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fvcw_pkg::cordic_t data_i,
  output logic              valid_o,
  output fvcw_pkg::cordic_t data_o
);

  localparam logic [31:0] ATAN = fvcw_pkg::atan_turn(SHIFT);

  logic              v_q;
  fvcw_pkg::cordic_t c_q, c_d;
  logic signed [fvcw_pkg::CW-1:0] xs, ys;

  assign xs = data_i.x >>> SHIFT;
  assign ys = data_i.y >>> SHIFT;

  always_comb begin
    c_d = data_i;
    if (!data_i.bypass) begin
      if (!data_i.y[fvcw_pkg::CW-1]) begin
        c_d.x = data_i.x + ys;
        c_d.y = data_i.y - xs;
        c_d.z = data_i.z + ATAN;
      end else begin
        c_d.x = data_i.x - ys;
        c_d.y = data_i.y + xs;
        c_d.z = data_i.z - ATAN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = c_q;

endmodule

[rtl/fvcw_color.sv]
// ----------------------------------------------------------------------------
// fvcw_color
// Turns radius and angle into a wheel color: gain correction and phase
// scaling, wheel blend, then saturation or dimming. Three register stages.
// ----------------------------------------------------------------------------
module fvcw_color #(
  parameter int unsigned FLOW_FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fvcw_pkg::cordic_t  data_i,
  output logic               valid_o,
  output fvcw_pkg::rgb_out_t data_o
);

  localparam int unsigned RW = fvcw_pkg::CW - FLOW_FRAC_BITS;

  // Stage 1: radius and wheel phase.
  logic                      v1_q, blank1_q;
  logic [fvcw_pkg::CW-1:0]   absx;
  logic [fvcw_pkg::CW+15:0]  gprod;
  logic [fvcw_pkg::CW-1:0]   mag_q, mag_d;
  logic [31:0]               phase;
  logic [37:0]               pprod;
  logic [5:0]                k0_q;
  logic [15:0]               f_q;

  assign absx  = data_i.x[fvcw_pkg::CW-1] ? fvcw_pkg::CW'(-data_i.x) : data_i.x;
  assign gprod = absx * fvcw_pkg::INV_GAIN_Q16;
  assign mag_d = data_i.bypass ? absx : gprod[fvcw_pkg::CW+15:16];
  assign phase = data_i.z + 32'h8000_0000;
  assign pprod = phase * 6'd54;

  // Stage 2: blended hue.
  logic [RW-1:0]       rad;
  logic                v2_q, blank2_q, inside2_q;
  logic [16:0]         rad2_q;
  logic [23:0]         w0, w1;
  logic [23:0]         c2_q [3];
  logic [23:0]         c2_d [3];

  assign rad = mag_q[fvcw_pkg::CW-1:FLOW_FRAC_BITS];
  assign w0  = fvcw_pkg::wheel_entry(k0_q);
  assign w1  = fvcw_pkg::wheel_entry(k0_q + 6'd1);

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      logic signed [8:0]  dw;
      logic signed [25:0] blend;
      dw       = $signed({1'b0, w1[8*(2-b) +: 8]}) - $signed({1'b0, w0[8*(2-b) +: 8]});
      blend    = $signed({2'b00, w0[8*(2-b) +: 8], 16'h0000})
               + $signed({1'b0, f_q}) * dw;
      c2_d[b]  = blend[23:0];
    end
  end

  // Stage 3: saturation inside the unit radius, dimming outside.
  logic      v3_q;
  logic [7:0] byte_d [3];
  fvcw_pkg::rgb_out_t rgb_q;

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      logic [23:0] dfull;
      logic [40:0] vin;
      logic [25:0] vout;
      dfull = fvcw_pkg::FULL_Q16 - c2_q[b];
      vin   = {1'b0, 8'd255, 32'h0} - 41'(rad2_q * dfull);
      vout  = 26'(c2_q[b] * 2'd3);
      if (blank2_q) begin
        byte_d[b] = 8'd0;
      end else if (inside2_q) begin
        byte_d[b] = vin[39:32];
      end else begin
        byte_d[b] = vout[25:18];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      blank1_q  <= data_i.blank;
      mag_q     <= mag_d;
      k0_q      <= pprod[37:32];
      f_q       <= pprod[31:16];
      blank2_q  <= blank1_q;
      inside2_q <= (rad <= RW'(65536));
      rad2_q    <= rad[16:0];
      c2_q      <= c2_d;
      rgb_q     <= {byte_d[0], byte_d[1], byte_d[2]};
    end
  end

  assign valid_o = v3_q;
  assign data_o  = rgb_q;

`ifndef ASSERT_OFF
  a_k0_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (k0_q <= fvcw_pkg::WHEEL_LAST))
    else $error("wheel index beyond last pair");

  a_zero_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && v2_q && !blank2_q && inside2_q && rad2_q == 17'd0)
      |=> (rgb_q == 24'hFFFFFF))
    else $error("zero radius did not give white");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable({v1_q, v2_q, v3_q}))
    else $error("pipeline moved while held");
`endif

endmodule
